@@ src/gbfp_pkg.sv @@
// Shared types and constants of the GNSS binary frame parser.
package gbfp_pkg;

  localparam int unsigned CfgDataW  = 32;
  localparam int unsigned CfgIndexW = 1;

  localparam logic [CfgIndexW-1:0] CfgMaxAccuracy = 1'd0;
  localparam logic [CfgIndexW-1:0] CfgMaxPayload  = 1'd1;

  localparam logic [15:0] MaxPayloadReset = 16'd248;

  localparam logic [7:0] SyncOne  = 8'hB5;
  localparam logic [7:0] SyncTwo  = 8'h62;
  localparam logic [7:0] ClassNav = 8'h01;
  localparam logic [7:0] ClassAck = 8'h05;
  localparam logic [7:0] ClassMon = 8'h0A;
  localparam logic [7:0] IdPosllh = 8'h02;
  localparam logic [7:0] IdStatus = 8'h03;
  localparam logic [7:0] IdVer    = 8'h04;
  localparam logic [7:0] IdAckAck = 8'h01;

  localparam logic [15:0] PosllhLen = 16'd28;
  // Payload offsets of the captured words, in units of four bytes.
  localparam logic [13:0] LonWord = 14'd1;  // bytes 4..7
  localparam logic [13:0] LatWord = 14'd2;  // bytes 8..11
  localparam logic [13:0] AccWord = 14'd5;  // bytes 20..23

  typedef enum logic [3:0] {
    PhHunt    = 4'd0,
    PhSync2   = 4'd1,
    PhClass   = 4'd2,
    PhId      = 4'd3,
    PhLenLo   = 4'd4,
    PhLenHi   = 4'd5,
    PhPayload = 4'd6,
    PhCkA     = 4'd7,
    PhCkB     = 4'd8
  } phase_e;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StChecksum = 2'd1,
    StTooBig   = 2'd2,
    StBadSync  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    DispHandled   = 2'd0,
    DispUnhandled = 2'd1,
    DispNak       = 2'd2,
    DispError     = 2'd3
  } dispatch_e;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  cls;
    logic [7:0]  id;
    logic [15:0] length;
    logic [1:0]  dispatch;
    logic [31:0] longitude;
    logic [31:0] latitude;
    logic [31:0] accuracy;
    logic        pos_valid;
    logic [7:0]  acked_class;
    logic [7:0]  acked_id;
  } result_t;

endpackage

@@ src/gnss_binary_frame_parser.sv @@
// Top level of the GNSS binary frame parser: byte-wise deframer and result register.
//
// Takes one received byte per transaction on the rx channel and finds frames of the form
// sync 0xB5 0x62, class, id, 16-bit little-endian length, payload, two Fletcher check
// bytes. One result transaction leaves on the res channel when a frame ends (ok or
// checksum fail) or aborts (length above max_payload_length, bad second sync byte); all
// other bytes give no result. Every byte is parsed in the cycle it is accepted, so the
// block takes one byte per clock while rx_ready_o is high; the result appears on
// res_valid_o in the cycle after the byte that closed the frame and sits in a single
// result register. rx_ready_o is low only while that register holds a result that the
// downstream side does not take in the same cycle. Good frames carry a dispatch code,
// NAV-POSLLH position fields with a valid flag gated by length and max_accuracy
// (register 0), and the acknowledged class and id of ACK-class frames. Configuration
// writes on cfg_we_i take effect at the next edge; write them only while the block is idle.
module gnss_binary_frame_parser (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [gbfp_pkg::CfgIndexW-1:0]  cfg_index_i,
  input  logic [gbfp_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic                            rx_valid_i,
  output logic                            rx_ready_o,
  input  logic [7:0]                      rx_byte_i,
  output logic                            res_valid_o,
  input  logic                            res_ready_i,
  output logic [1:0]                      frame_status_o,
  output logic [7:0]                      frame_class_o,
  output logic [7:0]                      frame_id_o,
  output logic [15:0]                     frame_length_o,
  output logic [1:0]                      dispatch_code_o,
  output logic signed [31:0]              longitude_o,
  output logic signed [31:0]              latitude_o,
  output logic [31:0]                     horizontal_accuracy_o,
  output logic                            position_valid_o,
  output logic [7:0]                      acked_class_o,
  output logic [7:0]                      acked_id_o
);
  import gbfp_pkg::*;

  // Configuration registers.
  logic [31:0] max_acc_q;
  logic [15:0] max_len_q;

  // Parse state.
  phase_e      phase_q, phase_d;
  logic [7:0]  sum_a_q, sum_a_d, sum_b_q, sum_b_d, ck_a_q, ck_a_d;
  logic [7:0]  cls_q, cls_d, id_q, id_d;
  logic [15:0] len_q, len_d, count_q, count_d;
  logic [31:0] lon_q, lon_d, lat_q, lat_d, acc_q, acc_d;
  logic [15:0] ack_q, ack_d;

  // Result register.
  logic        res_valid_q, res_valid_d;
  result_t     res_q, res_d;
  logic        emit;

  logic        rx_fire;
  logic [7:0]  sum_a_add, sum_b_add;
  logic [15:0] len_full, count_inc;
  logic [1:0]  byte_sel;

  // Hold a new byte only when the result slot is free or drains this cycle.
  assign rx_ready_o = !res_valid_q || res_ready_i;
  assign rx_fire    = rx_valid_i && rx_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_acc_q <= '0;
      max_len_q <= MaxPayloadReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgMaxAccuracy: max_acc_q <= cfg_data_i;
        CfgMaxPayload:  max_len_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // Fletcher update with the incoming byte.
  assign sum_a_add = sum_a_q + rx_byte_i;
  assign sum_b_add = sum_b_q + sum_a_add;
  assign len_full  = {rx_byte_i, len_q[7:0]};
  assign count_inc = count_q + 16'd1;
  assign byte_sel  = count_q[1:0];

  always_comb begin
    phase_d = phase_q;
    sum_a_d = sum_a_q;
    sum_b_d = sum_b_q;
    ck_a_d  = ck_a_q;
    cls_d   = cls_q;
    id_d    = id_q;
    len_d   = len_q;
    count_d = count_q;
    lon_d   = lon_q;
    lat_d   = lat_q;
    acc_d   = acc_q;
    ack_d   = ack_q;
    emit    = 1'b0;
    res_d   = '0;

    case (phase_q)
      PhSync2: begin
        if (rx_byte_i == SyncTwo) begin
          phase_d = PhClass;
        end else begin
          // Re-examine the offending byte as a first sync byte.
          phase_d        = (rx_byte_i == SyncOne) ? PhSync2 : PhHunt;
          emit           = 1'b1;
          res_d.status   = StBadSync;
          res_d.dispatch = DispError;
        end
      end
      PhClass: begin
        cls_d   = rx_byte_i;
        sum_a_d = sum_a_add;
        sum_b_d = sum_b_add;
        phase_d = PhId;
      end
      PhId: begin
        id_d    = rx_byte_i;
        sum_a_d = sum_a_add;
        sum_b_d = sum_b_add;
        phase_d = PhLenLo;
      end
      PhLenLo: begin
        len_d   = {8'd0, rx_byte_i};
        sum_a_d = sum_a_add;
        sum_b_d = sum_b_add;
        phase_d = PhLenHi;
      end
      PhLenHi: begin
        len_d   = len_full;
        sum_a_d = sum_a_add;
        sum_b_d = sum_b_add;
        if (len_full > max_len_q) begin
          // Abort as soon as the length is known.
          phase_d        = PhHunt;
          emit           = 1'b1;
          res_d.status   = StTooBig;
          res_d.cls      = cls_q;
          res_d.id       = id_q;
          res_d.length   = len_full;
          res_d.dispatch = DispError;
        end else begin
          phase_d = (len_full == 16'd0) ? PhCkA : PhPayload;
        end
      end
      PhPayload: begin
        sum_a_d = sum_a_add;
        sum_b_d = sum_b_add;
        // Capture the payload bytes that a result may carry.
        if (count_q < 16'd2) begin
          ack_d[8*count_q[0] +: 8] = rx_byte_i;
        end else if (count_q[15:2] == LonWord) begin
          lon_d[8*byte_sel +: 8] = rx_byte_i;
        end else if (count_q[15:2] == LatWord) begin
          lat_d[8*byte_sel +: 8] = rx_byte_i;
        end else if (count_q[15:2] == AccWord) begin
          acc_d[8*byte_sel +: 8] = rx_byte_i;
        end
        count_d = count_inc;
        if (count_inc >= len_q) begin
          phase_d = PhCkA;
        end
      end
      PhCkA: begin
        ck_a_d  = rx_byte_i;
        phase_d = PhCkB;
      end
      PhCkB: begin
        phase_d      = PhHunt;
        emit         = 1'b1;
        res_d.cls    = cls_q;
        res_d.id     = id_q;
        res_d.length = len_q;
        if (ck_a_q != sum_a_q || rx_byte_i != sum_b_q) begin
          res_d.status   = StChecksum;
          res_d.dispatch = DispError;
        end else begin
          res_d.status   = StOk;
          res_d.dispatch = DispUnhandled;
          if (cls_q == ClassNav) begin
            if (id_q == IdPosllh) begin
              res_d.dispatch  = DispHandled;
              res_d.longitude = lon_q;
              res_d.latitude  = lat_q;
              res_d.accuracy  = acc_q;
              res_d.pos_valid = (len_q == PosllhLen) && (acc_q <= max_acc_q);
            end else if (id_q == IdStatus) begin
              res_d.dispatch = DispHandled;
            end
          end else if (cls_q == ClassMon) begin
            if (id_q == IdVer) begin
              res_d.dispatch = DispHandled;
            end
          end else if (cls_q == ClassAck) begin
            res_d.dispatch    = (id_q == IdAckAck) ? DispHandled : DispNak;
            res_d.acked_class = ack_q[7:0];
            res_d.acked_id    = ack_q[15:8];
          end
        end
      end
      default: begin
        // Hunt: a first sync byte opens a fresh frame.
        if (rx_byte_i == SyncOne) begin
          phase_d = PhSync2;
          sum_a_d = '0;
          sum_b_d = '0;
          ck_a_d  = '0;
          cls_d   = '0;
          id_d    = '0;
          len_d   = '0;
          count_d = '0;
          lon_d   = '0;
          lat_d   = '0;
          acc_d   = '0;
          ack_d   = '0;
        end else begin
          phase_d = PhHunt;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHunt;
      sum_a_q <= '0;
      sum_b_q <= '0;
      ck_a_q  <= '0;
      cls_q   <= '0;
      id_q    <= '0;
      len_q   <= '0;
      count_q <= '0;
      lon_q   <= '0;
      lat_q   <= '0;
      acc_q   <= '0;
      ack_q   <= '0;
    end else if (rx_fire) begin
      phase_q <= phase_d;
      sum_a_q <= sum_a_d;
      sum_b_q <= sum_b_d;
      ck_a_q  <= ck_a_d;
      cls_q   <= cls_d;
      id_q    <= id_d;
      len_q   <= len_d;
      count_q <= count_d;
      lon_q   <= lon_d;
      lat_q   <= lat_d;
      acc_q   <= acc_d;
      ack_q   <= ack_d;
    end
  end

  // Keep a waiting result, load a new one, drop a taken one.
  assign res_valid_d = (res_valid_q && !res_ready_i) || (rx_fire && emit);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_fire && emit) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o           = res_valid_q;
  assign frame_status_o        = res_q.status;
  assign frame_class_o         = res_q.cls;
  assign frame_id_o            = res_q.id;
  assign frame_length_o        = res_q.length;
  assign dispatch_code_o       = res_q.dispatch;
  assign longitude_o           = res_q.longitude;
  assign latitude_o            = res_q.latitude;
  assign horizontal_accuracy_o = res_q.accuracy;
  assign position_valid_o      = res_q.pos_valid;
  assign acked_class_o         = res_q.acked_class;
  assign acked_id_o            = res_q.acked_id;

endmodule

@@ verif/tb_gnss_binary_frame_parser.sv @@
// Self-checking testbench for the GNSS binary frame parser: byte stream in, frame results out.
module tb_gnss_binary_frame_parser;
  timeunit 1ns;
  timeprecision 1ps;

  import gbfp_pkg::*;

  // Generous ceiling for the whole byte stream, stalls included.
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned PhaseBytes  = 130;
  localparam int unsigned SettleTicks = 8;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [CfgIndexW-1:0] cfg_index_i = CfgMaxAccuracy;
  logic [CfgDataW-1:0]  cfg_data_i  = '0;
  logic                 rx_valid_i  = 1'b0;
  logic                 rx_ready_o;
  logic [7:0]           rx_byte_i   = 8'h00;
  logic                 res_valid_o;
  logic                 res_ready_i = 1'b0;
  logic [1:0]           frame_status_o;
  logic [7:0]           frame_class_o;
  logic [7:0]           frame_id_o;
  logic [15:0]          frame_length_o;
  logic [1:0]           dispatch_code_o;
  logic signed [31:0]   longitude_o;
  logic signed [31:0]   latitude_o;
  logic [31:0]          horizontal_accuracy_o;
  logic                 position_valid_o;
  logic [7:0]           acked_class_o;
  logic [7:0]           acked_id_o;

  gnss_binary_frame_parser dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_we_i              (cfg_we_i),
    .cfg_index_i           (cfg_index_i),
    .cfg_data_i            (cfg_data_i),
    .rx_valid_i            (rx_valid_i),
    .rx_ready_o            (rx_ready_o),
    .rx_byte_i             (rx_byte_i),
    .res_valid_o           (res_valid_o),
    .res_ready_i           (res_ready_i),
    .frame_status_o        (frame_status_o),
    .frame_class_o         (frame_class_o),
    .frame_id_o            (frame_id_o),
    .frame_length_o        (frame_length_o),
    .dispatch_code_o       (dispatch_code_o),
    .longitude_o           (longitude_o),
    .latitude_o            (latitude_o),
    .horizontal_accuracy_o (horizontal_accuracy_o),
    .position_valid_o      (position_valid_o),
    .acked_class_o         (acked_class_o),
    .acked_id_o            (acked_id_o)
  );

  // 20 ns clock.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Stimulus bytes waiting for the rx driver, and frame results the parser still owes us.
  logic [7:0] line_bytes[$];
  result_t    frames_due[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned mismatches    = 0;
  int unsigned cycle_count   = 0;

  // Shadow copy of the two configuration registers, at their reset values.
  logic [31:0] acc_limit = 32'd0;
  logic [15:0] len_limit = MaxPayloadReset;

  // Shadow copy of the deframer state.
  phase_e      parse_ph  = PhHunt;
  logic [7:0]  fl_sum_a  = '0;
  logic [7:0]  fl_sum_b  = '0;
  logic [7:0]  ck_a_seen = '0;
  logic [7:0]  hdr_class = '0;
  logic [7:0]  hdr_id    = '0;
  logic [15:0] hdr_len   = '0;
  logic [15:0] pay_count = '0;
  logic [31:0] cap_lon   = '0;
  logic [31:0] cap_lat   = '0;
  logic [31:0] cap_acc   = '0;
  logic [15:0] cap_ack   = '0;

  // ---------------------------------------------------------------------------
  // Frame predictor
  // ---------------------------------------------------------------------------

  task automatic fletcher_add(input logic [7:0] b);
    fl_sum_a = fl_sum_a + b;
    fl_sum_b = fl_sum_b + fl_sum_a;
  endtask

  // Abort result: header only where the frame got that far, dispatch marks the error.
  function automatic result_t error_frame(input status_e st, input bit with_hdr);
    result_t r;
    r          = '0;
    r.status   = st;
    r.dispatch = DispError;
    if (with_hdr) begin
      r.cls    = hdr_class;
      r.id     = hdr_id;
      r.length = hdr_len;
    end
    return r;
  endfunction

  // Result of a frame whose check bytes matched.
  function automatic result_t good_frame();
    result_t r;
    r          = '0;
    r.status   = StOk;
    r.cls      = hdr_class;
    r.id       = hdr_id;
    r.length   = hdr_len;
    r.dispatch = DispUnhandled;
    case (hdr_class)
      ClassNav: begin
        if (hdr_id == IdPosllh) begin
          r.dispatch  = DispHandled;
          r.longitude = cap_lon;
          r.latitude  = cap_lat;
          r.accuracy  = cap_acc;
          r.pos_valid = (hdr_len == PosllhLen) && (cap_acc <= acc_limit);
        end else if (hdr_id == IdStatus) begin
          r.dispatch = DispHandled;
        end
      end
      ClassMon: begin
        if (hdr_id == IdVer) r.dispatch = DispHandled;
      end
      ClassAck: begin
        r.dispatch    = (hdr_id == IdAckAck) ? DispHandled : DispNak;
        r.acked_class = cap_ack[7:0];
        r.acked_id    = cap_ack[15:8];
      end
      default: ;
    endcase
    return r;
  endfunction

  // Advance the shadow deframer by one accepted byte; queue the result it causes, if any.
  task automatic deframe_byte(input logic [7:0] b);
    logic [15:0] pos;
    pos = pay_count;
    case (parse_ph)
      PhSync2: begin
        if (b == SyncTwo) begin
          parse_ph = PhClass;
        end else begin
          // A repeated first sync byte keeps us waiting for the second one.
          if (b == SyncOne) parse_ph = PhSync2;
          else parse_ph = PhHunt;
          frames_due.push_back(error_frame(StBadSync, 1'b0));
        end
      end
      PhClass: begin
        hdr_class = b;
        fletcher_add(b);
        parse_ph = PhId;
      end
      PhId: begin
        hdr_id = b;
        fletcher_add(b);
        parse_ph = PhLenLo;
      end
      PhLenLo: begin
        hdr_len = {8'h00, b};
        fletcher_add(b);
        parse_ph = PhLenHi;
      end
      PhLenHi: begin
        hdr_len[15:8] = b;
        fletcher_add(b);
        if (hdr_len > len_limit) begin
          parse_ph = PhHunt;
          frames_due.push_back(error_frame(StTooBig, 1'b1));
        end else if (hdr_len == 16'd0) begin
          parse_ph = PhCkA;
        end else begin
          parse_ph = PhPayload;
        end
      end
      PhPayload: begin
        fletcher_add(b);
        if (pos < 16'd2) cap_ack[8*pos[0] +: 8] = b;
        else if (pos >= 16'd4 && pos < 16'd8) cap_lon[8*pos[1:0] +: 8] = b;
        else if (pos >= 16'd8 && pos < 16'd12) cap_lat[8*pos[1:0] +: 8] = b;
        else if (pos >= 16'd20 && pos < 16'd24) cap_acc[8*pos[1:0] +: 8] = b;
        pay_count = pay_count + 16'd1;
        if (pay_count >= hdr_len) parse_ph = PhCkA;
      end
      PhCkA: begin
        ck_a_seen = b;
        parse_ph  = PhCkB;
      end
      PhCkB: begin
        parse_ph = PhHunt;
        if (ck_a_seen != fl_sum_a || b != fl_sum_b) begin
          frames_due.push_back(error_frame(StChecksum, 1'b1));
        end else begin
          frames_due.push_back(good_frame());
        end
      end
      default: begin
        // Hunting: a first sync byte opens a fresh frame.
        if (b == SyncOne) begin
          fl_sum_a  = '0;
          fl_sum_b  = '0;
          ck_a_seen = '0;
          hdr_class = '0;
          hdr_id    = '0;
          hdr_len   = '0;
          pay_count = '0;
          cap_lon   = '0;
          cap_lat   = '0;
          cap_acc   = '0;
          cap_ack   = '0;
          parse_ph  = PhSync2;
        end else begin
          parse_ph = PhHunt;
        end
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus generation
  // ---------------------------------------------------------------------------

  // Queue one frame. Stop after the header when the length will be rejected.
  // ck_fault 1 corrupts the first check byte, 2 the second.
  task automatic push_frame(input logic [7:0] cls, input logic [7:0] id,
                            input logic [15:0] len, input logic [31:0] acc,
                            input int unsigned ck_fault);
    logic [7:0]  hdr[4];
    logic [7:0]  sum_a;
    logic [7:0]  sum_b;
    logic [7:0]  pb;
    int unsigned i;
    hdr   = '{cls, id, len[7:0], len[15:8]};
    sum_a = '0;
    sum_b = '0;
    line_bytes.push_back(SyncOne);
    line_bytes.push_back(SyncTwo);
    for (i = 0; i < 4; i++) begin
      line_bytes.push_back(hdr[i]);
      sum_a = sum_a + hdr[i];
      sum_b = sum_b + sum_a;
    end
    if (len <= len_limit) begin
      for (i = 0; i < len; i++) begin
        pb = 8'($urandom);
        // Put the chosen accuracy where a position frame carries it.
        if (cls == ClassNav && id == IdPosllh && i >= 20 && i < 24) pb = acc[8*(i-20) +: 8];
        line_bytes.push_back(pb);
        sum_a = sum_a + pb;
        sum_b = sum_b + sum_a;
      end
      if (ck_fault == 1) sum_a = sum_a ^ 8'($urandom_range(255, 1));
      if (ck_fault == 2) sum_b = sum_b ^ 8'($urandom_range(255, 1));
      line_bytes.push_back(sum_a);
      line_bytes.push_back(sum_b);
    end
  endtask

  // Mostly well-formed frames with random content, plus noise and broken frames.
  task automatic gen_traffic(input int unsigned n);
    int unsigned kind;
    int unsigned fault;
    int unsigned i;
    logic [7:0]  cls;
    logic [7:0]  id;
    logic [7:0]  b;
    logic [15:0] len;
    logic [15:0] cap;
    logic [31:0] acc;
    while (line_bytes.size() < n) begin
      kind = $urandom_range(99);
      if (kind < 68 || (kind < 78 && len_limit == 16'hFFFF)) begin
        case ($urandom_range(7))
          0, 1: begin cls = ClassNav; id = IdPosllh; end
          2: begin cls = ClassNav; id = IdStatus; end
          3: begin cls = ClassNav; id = 8'($urandom); end
          4: begin cls = ClassMon; id = ($urandom_range(1) != 0) ? IdVer : 8'($urandom); end
          5: begin cls = ClassAck; id = IdAckAck; end
          6: begin cls = ClassAck; id = 8'($urandom); end
          default: begin cls = 8'($urandom); id = 8'($urandom); end
        endcase
        cap = (len_limit < 16'd40) ? len_limit : 16'd40;
        if (cls == ClassNav && id == IdPosllh && len_limit >= PosllhLen &&
            $urandom_range(2) != 0) begin
          len = PosllhLen;
        end else if ($urandom_range(19) == 0) begin
          len = 16'($urandom_range(0, (len_limit < 16'd300) ? len_limit : 16'd300));
        end else begin
          len = 16'($urandom_range(0, cap));
        end
        case ($urandom_range(3))
          0: acc = acc_limit;
          1: acc = acc_limit + 32'd1;
          2: acc = acc_limit - 32'd1;
          default: acc = $urandom;
        endcase
        fault = ($urandom_range(99) < 15) ? $urandom_range(2, 1) : 0;
        push_frame(cls, id, len, acc, fault);
      end else if (kind < 78) begin
        // Header with a length above the limit.
        if ($urandom_range(3) == 0) len = 16'hFFFF;
        else len = len_limit + 16'($urandom_range(1, 16'hFFFF - len_limit));
        push_frame(8'($urandom), 8'($urandom), len, 32'd0, 0);
      end else if (kind < 86) begin
        // First sync byte followed by anything but the second one.
        b = 8'($urandom);
        if (b == SyncTwo) b = SyncOne;
        line_bytes.push_back(SyncOne);
        line_bytes.push_back(b);
      end else if (kind < 93) begin
        // Line noise; keep it from opening stray frames of random length.
        for (i = $urandom_range(4, 1); i > 0; i--) begin
          b = 8'($urandom);
          if (b == SyncOne) b = 8'hB4;
          line_bytes.push_back(b);
        end
      end else begin
        // Frame cut short: what follows is eaten as its payload and check bytes.
        len = 16'($urandom_range(1, 16));
        if (len > len_limit) len = len_limit;
        line_bytes.push_back(SyncOne);
        line_bytes.push_back(SyncTwo);
        line_bytes.push_back(8'($urandom));
        line_bytes.push_back(8'($urandom));
        line_bytes.push_back(len[7:0]);
        line_bytes.push_back(len[15:8]);
        for (i = $urandom_range(len, 0); i > 0; i--) line_bytes.push_back(8'($urandom));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequencing helpers
  // ---------------------------------------------------------------------------

  // Write one register and keep the shadow copy in step.
  task automatic cfg_write(input logic [CfgIndexW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgMaxAccuracy) acc_limit = val;
    else len_limit = val[15:0];
  endtask

  // Wait until every byte is taken and every result has come back, then let the
  // parser settle before touching the registers.
  task automatic wait_drained();
    while (line_bytes.size() != 0 || rx_valid_i || frames_due.size() != 0) @(posedge clk_i);
    repeat (SettleTicks) @(posedge clk_i);
  endtask

  task automatic run_phase(input logic [31:0] acc, input logic [15:0] len,
                           input int unsigned spct, input int unsigned rpct);
    cfg_write(CfgMaxAccuracy, acc);
    cfg_write(CfgMaxPayload, {16'h0000, len});
    send_idle_pct = spct;
    recv_idle_pct = rpct;
    gen_traffic(PhaseBytes);
    wait_drained();
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // rx driver: present queued bytes, hold each until its transaction completes
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rx_valid_i <= 1'b0;
    end else begin
      // A transaction completed at this edge: feed the predictor.
      if (rx_valid_i && rx_ready_o) deframe_byte(rx_byte_i);
      // Slot free: present the next byte or leave the channel idle.
      if (!rx_valid_i || rx_ready_o) begin
        if (line_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          rx_valid_i <= 1'b1;
          rx_byte_i  <= line_bytes.pop_front();
        end else begin
          rx_valid_i <= 1'b0;
          rx_byte_i  <= 8'($urandom);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: compare each result transaction with the oldest prediction
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin : monitor
    result_t due;
    if (rst_ni) begin
      if (res_valid_o && res_ready_i) begin
        if (frames_due.size() == 0) begin
          $display("%0t: unexpected result, expected none actual status %0h class %0h id %0h",
                   $time, frame_status_o, frame_class_o, frame_id_o);
          mismatches++;
        end else begin
          due = frames_due.pop_front();
          check_field("frame_status", due.status, frame_status_o);
          check_field("frame_class", due.cls, frame_class_o);
          check_field("frame_id", due.id, frame_id_o);
          check_field("frame_length", due.length, frame_length_o);
          check_field("dispatch_code", due.dispatch, dispatch_code_o);
          check_field("longitude", due.longitude, longitude_o);
          check_field("latitude", due.latitude, latitude_o);
          check_field("horizontal_accuracy", due.accuracy, horizontal_accuracy_o);
          check_field("position_valid", due.pos_valid, position_valid_o);
          check_field("acked_class", due.acked_class, acked_class_o);
          check_field("acked_id", due.acked_id, acked_id_o);
        end
      end
      // Stall the result side at random.
      res_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Drop the run if it hangs.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("%0t: timeout with %0d results outstanding", $time, frames_due.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed frames under the reset settings (accuracy limit 0, length limit 248).
    send_idle_pct = 15;
    recv_idle_pct = 63;
    line_bytes.push_back(SyncOne);                       // bad second sync byte
    line_bytes.push_back(8'h00);
    line_bytes.push_back(SyncOne);                       // repeated first sync, then a frame
    push_frame(ClassMon, IdVer, 16'd0, 32'd0, 0);
    push_frame(ClassAck, IdAckAck, 16'd2, 32'd0, 0);     // acknowledge
    push_frame(ClassAck, 8'h00, 16'd2, 32'd0, 0);        // negative acknowledge
    push_frame(ClassAck, IdAckAck, 16'd1, 32'd0, 0);     // acknowledge missing its id byte
    push_frame(ClassNav, IdStatus, 16'd0, 32'd0, 0);
    push_frame(ClassNav, IdPosllh, PosllhLen, 32'd0, 0); // accuracy at the limit
    push_frame(ClassNav, IdPosllh, PosllhLen, 32'd1, 0); // accuracy just over
    push_frame(ClassNav, IdPosllh, 16'd10, 32'd0, 0);    // position of the wrong length
    push_frame(8'hFF, 8'hFF, 16'd0, 32'd0, 0);           // unhandled frame
    push_frame(ClassNav, IdPosllh, PosllhLen, 32'd0, 1); // first check byte wrong
    push_frame(ClassMon, IdVer, 16'd0, 32'd0, 2);        // second check byte wrong
    push_frame(ClassNav, IdPosllh, 16'hFFFF, 32'd0, 0);  // largest length, too big
    push_frame(8'h00, 8'h00, 16'd249, 32'd0, 0);         // one over the limit
    push_frame(8'h00, 8'h00, 16'd248, 32'd0, 0);         // exactly at the limit
    line_bytes.push_back(8'hFF);
    line_bytes.push_back(8'h00);
    wait_drained();

    // Random phases across register settings and idle patterns.
    run_phase(32'hFFFF_FFFF, 16'hFFFF, 15, 63);
    run_phase(32'd0, 16'd0, 15, 63);
    run_phase($urandom, PosllhLen, 63, 15);
    run_phase(32'($urandom_range(1000)), 16'($urandom_range(300, 29)), 63, 15);
    run_phase(32'h8000_0000, MaxPayloadReset, 0, 0);
    run_phase($urandom, 16'd40, 0, 0);

    repeat (SettleTicks) @(posedge clk_i);
    if (mismatches == 0 && frames_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/gbfp_pkg.sv
src/gnss_binary_frame_parser.sv
verif/tb_gnss_binary_frame_parser.sv
